>>> design/rjr_pkg.sv
// rjr_pkg: shared types, codes and constants for the remote jog ramp block
// no dependencies; every other design file refers to it by scoped names
`timescale 1ns / 1ps

package rjr_pkg;

    // frame body length saturates here
    localparam int FRAME_MAX   = 31;
    localparam int FRAME_LEN_W = $clog2(FRAME_MAX + 1);

    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int STEP_W    = 8;
    localparam int SPEED_W   = 10;
    localparam int VEL_W     = 11;
    localparam int NUM_DIR   = 4;
    localparam int DIR_IDX_W = 2;

    // apb register file
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_JOG_STEP = 2'd0;
    localparam logic [1:0] REG_LIMIT_BR = 2'd1;
    localparam logic [1:0] REG_LIMIT_FL = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    // register reset values
    localparam logic [STEP_W-1:0]  RST_JOG_STEP = 8'd20;
    localparam logic [SPEED_W-1:0] RST_LIMIT_BR = 10'd150;
    localparam logic [SPEED_W-1:0] RST_LIMIT_FL = 10'd105;
    localparam logic [TIME_W-1:0]  RST_TIMEOUT  = 32'd300000;

    // direction slots
    localparam logic [DIR_IDX_W-1:0] DIR_FWD   = 2'd0;
    localparam logic [DIR_IDX_W-1:0] DIR_BWD   = 2'd1;
    localparam logic [DIR_IDX_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_IDX_W-1:0] DIR_RIGHT = 2'd3;

    // link characters
    localparam logic [BYTE_W-1:0] CH_FRAME_START = 8'h23; // '#'
    localparam logic [BYTE_W-1:0] CH_FRAME_END   = 8'h24; // '$'
    localparam logic [BYTE_W-1:0] CH_SKIP        = 8'h21; // '!'
    localparam logic [BYTE_W-1:0] CH_FWD         = 8'h46; // 'F'
    localparam logic [BYTE_W-1:0] CH_BWD         = 8'h42; // 'B'
    localparam logic [BYTE_W-1:0] CH_LEFT        = 8'h4C; // 'L'
    localparam logic [BYTE_W-1:0] CH_RIGHT       = 8'h52; // 'R'
    localparam logic [BYTE_W-1:0] CH_CENTRE      = 8'h4D; // 'M'

    typedef struct packed {
        logic [STEP_W-1:0]  jog_step;
        logic [SPEED_W-1:0] limit_back_right;
        logic [SPEED_W-1:0] limit_fwd_left;
        logic [TIME_W-1:0]  timeout_us;
    } rjr_cfg_t;

    typedef struct packed {
        logic s1_valid;
        logic s2_adv;
        logic in_frame;
    } rjr_stat_t;

    // add one step, clip to the limit (also clips a speed held above a lowered limit)
    function automatic logic [SPEED_W-1:0] sat_add(
        input logic [SPEED_W-1:0] speed,
        input logic [STEP_W-1:0]  step,
        input logic [SPEED_W-1:0] limit
    );
        logic [SPEED_W:0] sum;
        sum = {1'b0, speed} + {{(SPEED_W + 1 - STEP_W){1'b0}}, step};
        if (sum > {1'b0, limit})
        begin
            return limit;
        end
        return sum[SPEED_W-1:0];
    endfunction

endpackage

>>> design/rjr_req_if.sv
// rjr_req_if: valid/ready request channel carrying one command transaction
// depends on rjr_pkg for field widths
`timescale 1ns / 1ps

interface rjr_req_if;
    logic                           valid;
    logic                           ready;
    logic [rjr_pkg::CMD_W-1:0]      command;
    logic [rjr_pkg::BYTE_W-1:0]     rx_byte;
    logic [rjr_pkg::TIME_W-1:0]     time_now;

    modport source (output valid, command, rx_byte, time_now, input ready);
    modport sink   (input valid, command, rx_byte, time_now, output ready);
endinterface

>>> design/rjr_rsp_if.sv
// rjr_rsp_if: valid/ready result channel carrying one status transaction
// depends on rjr_pkg for field widths
`timescale 1ns / 1ps

interface rjr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [rjr_pkg::VEL_W-1:0]   target_x;
    logic signed [rjr_pkg::VEL_W-1:0]   target_y;
    logic signed [rjr_pkg::VEL_W-1:0]   nav_x;
    logic signed [rjr_pkg::VEL_W-1:0]   nav_y;
    logic                               nav_enable;
    logic                               centre_request;
    logic                               frame_end;

    modport source (output valid, target_x, target_y, nav_x, nav_y, nav_enable,
                    centre_request, frame_end, input ready);
    modport sink   (input valid, target_x, target_y, nav_x, nav_y, nav_enable,
                    centre_request, frame_end, output ready);
endinterface

>>> design/rjr_regs.sv
// rjr_regs: apb configuration register file (step, two limits, timeout)
// depends on rjr_pkg
`timescale 1ns / 1ps

module rjr_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rjr_pkg::PADDR_W-1:0]    paddr,
    input  logic [rjr_pkg::PDATA_W-1:0]    pwdata,
    output logic [rjr_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output rjr_pkg::rjr_cfg_t              cfg
);

    rjr_pkg::rjr_cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jog_step         <= rjr_pkg::RST_JOG_STEP;
            cfg_reg.limit_back_right <= rjr_pkg::RST_LIMIT_BR;
            cfg_reg.limit_fwd_left   <= rjr_pkg::RST_LIMIT_FL;
            cfg_reg.timeout_us       <= rjr_pkg::RST_TIMEOUT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rjr_pkg::REG_JOG_STEP:
                    cfg_reg.jog_step <= pwdata[rjr_pkg::STEP_W-1:0];
                rjr_pkg::REG_LIMIT_BR:
                    cfg_reg.limit_back_right <= pwdata[rjr_pkg::SPEED_W-1:0];
                rjr_pkg::REG_LIMIT_FL:
                    cfg_reg.limit_fwd_left <= pwdata[rjr_pkg::SPEED_W-1:0];
                rjr_pkg::REG_TIMEOUT:
                    cfg_reg.timeout_us <= pwdata[rjr_pkg::TIME_W-1:0];
                default:
                    cfg_reg.timeout_us <= cfg_reg.timeout_us;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rjr_pkg::REG_JOG_STEP:
                prdata = {{(rjr_pkg::PDATA_W - rjr_pkg::STEP_W){1'b0}}, cfg_reg.jog_step};
            rjr_pkg::REG_LIMIT_BR:
                prdata = {{(rjr_pkg::PDATA_W - rjr_pkg::SPEED_W){1'b0}},
                          cfg_reg.limit_back_right};
            rjr_pkg::REG_LIMIT_FL:
                prdata = {{(rjr_pkg::PDATA_W - rjr_pkg::SPEED_W){1'b0}},
                          cfg_reg.limit_fwd_left};
            rjr_pkg::REG_TIMEOUT:
                prdata = cfg_reg.timeout_us;
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> design/rjr_core.sv
// rjr_core: input register, one-pass state update and result registers
// depends on rjr_pkg, rjr_req_if and rjr_rsp_if
`timescale 1ns / 1ps

module rjr_core (
    input  logic               clk,
    input  logic               rst_n,
    input  rjr_pkg::rjr_cfg_t  cfg,
    rjr_req_if.sink            req,
    rjr_rsp_if.source          rsp,
    output rjr_pkg::rjr_stat_t stat
);

    localparam int LEN_W = rjr_pkg::FRAME_LEN_W;

    // input register
    logic                          s1_valid_reg;
    logic [rjr_pkg::CMD_W-1:0]     s1_cmd_reg;
    logic [rjr_pkg::BYTE_W-1:0]    s1_byte_reg;
    logic [rjr_pkg::TIME_W-1:0]    s1_time_reg;

    // block state, which also serves as the result register
    logic [rjr_pkg::SPEED_W-1:0]   speed_reg [rjr_pkg::NUM_DIR];
    logic [rjr_pkg::SPEED_W-1:0]   speed_next[rjr_pkg::NUM_DIR];
    logic [rjr_pkg::TIME_W-1:0]    stamp_reg [rjr_pkg::NUM_DIR];
    logic [rjr_pkg::TIME_W-1:0]    stamp_next[rjr_pkg::NUM_DIR];
    logic                          in_frame_reg, in_frame_next;
    logic [LEN_W-1:0]              frame_len_reg, frame_len_next;
    logic                          centre_reg, centre_next;
    logic signed [rjr_pkg::VEL_W-1:0] vel_x_reg, vel_x_next;
    logic signed [rjr_pkg::VEL_W-1:0] vel_y_reg, vel_y_next;
    logic signed [rjr_pkg::VEL_W-1:0] nav_x_reg, nav_x_next;
    logic signed [rjr_pkg::VEL_W-1:0] nav_y_reg, nav_y_next;
    logic                          nav_on_reg, nav_on_next;
    logic                          fend_reg, fend_next;
    logic                          out_valid_reg;

    logic                          s2_adv;
    logic                          update;
    logic [rjr_pkg::SPEED_W-1:0]   live_speed[rjr_pkg::NUM_DIR];
    logic [rjr_pkg::TIME_W-1:0]    age[rjr_pkg::NUM_DIR];

    assign s2_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s2_adv;
    assign update    = s1_valid_reg && s2_adv;

    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_adv   = s2_adv;
    assign stat.in_frame = in_frame_reg;

    // timeout check per direction: modular age against the timeout
    always_comb
    begin
        for (int i = 0; i < rjr_pkg::NUM_DIR; i++)
        begin
            age[i]        = s1_time_reg - stamp_reg[i];
            live_speed[i] = (age[i] > cfg.timeout_us) ? '0 : speed_reg[i];
        end
    end

    always_comb
    begin
        speed_next     = speed_reg;
        stamp_next     = stamp_reg;
        in_frame_next  = in_frame_reg;
        frame_len_next = frame_len_reg;
        centre_next    = centre_reg;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        nav_x_next     = nav_x_reg;
        nav_y_next     = nav_y_reg;
        nav_on_next    = nav_on_reg;
        fend_next      = 1'b0;

        unique case (s1_cmd_reg)
            rjr_pkg::CMD_BYTE:
            begin
                if (!in_frame_reg)
                begin
                    if (s1_byte_reg == rjr_pkg::CH_FRAME_START)
                    begin
                        in_frame_next  = 1'b1;
                        frame_len_next = '0;
                    end
                    else
                    begin
                        // keys; the skip character and others fall to default
                        case (s1_byte_reg)
                            rjr_pkg::CH_FWD:
                            begin
                                speed_next[rjr_pkg::DIR_FWD] = rjr_pkg::sat_add(
                                    speed_reg[rjr_pkg::DIR_FWD], cfg.jog_step,
                                    cfg.limit_fwd_left);
                                stamp_next[rjr_pkg::DIR_FWD] = s1_time_reg;
                            end
                            rjr_pkg::CH_BWD:
                            begin
                                speed_next[rjr_pkg::DIR_BWD] = rjr_pkg::sat_add(
                                    speed_reg[rjr_pkg::DIR_BWD], cfg.jog_step,
                                    cfg.limit_back_right);
                                stamp_next[rjr_pkg::DIR_BWD] = s1_time_reg;
                            end
                            rjr_pkg::CH_LEFT:
                            begin
                                speed_next[rjr_pkg::DIR_LEFT] = rjr_pkg::sat_add(
                                    speed_reg[rjr_pkg::DIR_LEFT], cfg.jog_step,
                                    cfg.limit_fwd_left);
                                stamp_next[rjr_pkg::DIR_LEFT] = s1_time_reg;
                            end
                            rjr_pkg::CH_RIGHT:
                            begin
                                speed_next[rjr_pkg::DIR_RIGHT] = rjr_pkg::sat_add(
                                    speed_reg[rjr_pkg::DIR_RIGHT], cfg.jog_step,
                                    cfg.limit_back_right);
                                stamp_next[rjr_pkg::DIR_RIGHT] = s1_time_reg;
                            end
                            rjr_pkg::CH_CENTRE:
                            begin
                                for (int i = 0; i < rjr_pkg::NUM_DIR; i++)
                                begin
                                    speed_next[i] = '0;
                                end
                                centre_next = 1'b1;
                            end
                            default:
                            begin
                                centre_next = centre_reg;
                            end
                        endcase
                    end
                end
                else if (s1_byte_reg == rjr_pkg::CH_FRAME_END)
                begin
                    in_frame_next = 1'b0;
                    fend_next     = (frame_len_reg != '0);
                end
                else if (frame_len_reg < LEN_W'(rjr_pkg::FRAME_MAX))
                begin
                    frame_len_next = frame_len_reg + 1'b1;
                end
            end
            rjr_pkg::CMD_TICK:
            begin
                speed_next = live_speed;
                vel_x_next = $signed({1'b0, live_speed[rjr_pkg::DIR_FWD]})
                           - $signed({1'b0, live_speed[rjr_pkg::DIR_BWD]});
                vel_y_next = $signed({1'b0, live_speed[rjr_pkg::DIR_RIGHT]})
                           - $signed({1'b0, live_speed[rjr_pkg::DIR_LEFT]});
                if (!centre_reg)
                begin
                    if (vel_x_next != '0 || vel_y_next != '0)
                    begin
                        nav_x_next  = vel_x_next;
                        nav_y_next  = vel_y_next;
                        nav_on_next = 1'b1;
                    end
                    else
                    begin
                        nav_on_next = 1'b0;
                    end
                end
            end
            rjr_pkg::CMD_CLEAR:
            begin
                centre_next = 1'b0;
            end
            default:
            begin
                centre_next = centre_reg;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg  <= req.command;
            s1_byte_reg <= req.rx_byte;
            s1_time_reg <= req.time_now;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rjr_pkg::NUM_DIR; i++)
            begin
                speed_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
            in_frame_reg  <= 1'b0;
            frame_len_reg <= '0;
            centre_reg    <= 1'b0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            nav_x_reg     <= '0;
            nav_y_reg     <= '0;
            nav_on_reg    <= 1'b0;
            fend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (update)
            begin
                speed_reg     <= speed_next;
                stamp_reg     <= stamp_next;
                in_frame_reg  <= in_frame_next;
                frame_len_reg <= frame_len_next;
                centre_reg    <= centre_next;
                vel_x_reg     <= vel_x_next;
                vel_y_reg     <= vel_y_next;
                nav_x_reg     <= nav_x_next;
                nav_y_reg     <= nav_y_next;
                nav_on_reg    <= nav_on_next;
                fend_reg      <= fend_next;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.target_x       = vel_x_reg;
    assign rsp.target_y       = vel_y_reg;
    assign rsp.nav_x          = nav_x_reg;
    assign rsp.nav_y          = nav_y_reg;
    assign rsp.nav_enable     = nav_on_reg;
    assign rsp.centre_request = centre_reg;
    assign rsp.frame_end      = fend_reg;

endmodule

>>> design/remote_jog_ramp_with_deadman.sv
// remote_jog_ramp_with_deadman: top level, register file plus processing core
// depends on rjr_pkg, rjr_req_if, rjr_rsp_if, rjr_regs and rjr_core
`timescale 1ns / 1ps

// remote jog controller: each request transaction carries a command (link byte,
// update tick or centre-flag clear) and a microsecond timestamp, and produces
// exactly one response transaction with the velocity, navigation and flag
// outputs as they stand after that command. bytes between '#' and '$' are only
// framed and counted; outside a frame F/B/L/R ramp a direction speed by the
// jog step up to its limit, and M zeroes all speeds and raises the centre
// request. a tick drops any direction whose last key is older than timeout_us,
// then forms target_x/target_y and, unless a centre request is pending, updates
// the navigation outputs. timing: one transaction per clock sustained while
// responses are taken; a request is captured in the input register, and the
// state/result registers load from it once the response side can advance. while
// a response waits, an empty input register still takes one more request, then
// the request side stalls until the response is taken. configuration writes are
// taken over apb and must only happen while no transaction is in flight.

module remote_jog_ramp_with_deadman (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rjr_pkg::PADDR_W-1:0]    paddr,
    input  logic [rjr_pkg::PDATA_W-1:0]    pwdata,
    output logic [rjr_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    rjr_req_if.sink                        req,
    rjr_rsp_if.source                      rsp
);

    // live configuration shared with the core
    rjr_pkg::rjr_cfg_t  cfg;
    // pipeline status for checks
    rjr_pkg::rjr_stat_t stat;

    rjr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register feeds a single pass of update logic into the state regs,
    // which double as the response register
    rjr_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp),
        .stat  (stat)
    );

`ifndef ASSERT_OFF
    // navigation is only enabled with a nonzero latched velocity
    a_nav_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.nav_enable |-> (rsp.nav_x != '0 || rsp.nav_y != '0))
        else $error("nav enabled with zero latched velocity");

    // a request is only taken when the input register is free or moving on
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> (!stat.s1_valid || stat.s2_adv))
        else $error("request accepted into a full input register");

    // a stalled input register keeps its transaction
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stat.s1_valid && !stat.s2_adv |=> stat.s1_valid)
        else $error("input register lost a stalled transaction");
`endif

endmodule
